// ===== src/sorted_list_insert_remove_core_defines.svh =====
// Assertion macros shared by the sorted list core.
`ifndef SORTED_LIST_INSERT_REMOVE_CORE_DEFINES_SVH
`define SORTED_LIST_INSERT_REMOVE_CORE_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define SLRI_ASSERT(name, clock, rst_n, prop, msg) \
	name: assert property (@(posedge clock) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, checked during reset as well.
`define SLRI_ASSERT_ALWAYS(name, clock, prop, msg) \
	name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/slri_pkg.sv =====
// Package for the sorted list core: sizes, status codes and cell types.
package slri_pkg;
	localparam int CAPACITY  = 16;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int OUT_CNT_W = 5;
	localparam int VAL_W     = 32;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_REMOVE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic                    ins;
		logic                    rem;
		logic signed [VAL_W-1:0] value;
	} op_t;

	typedef struct packed {
		logic                    valid;
		logic                    ge;
		logic signed [VAL_W-1:0] value;
	} link_t;
endpackage

// ===== src/slri_cell.sv =====
// One storage cell of the sorted chain: holds an entry and shifts with its neighbors.
module slri_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  slri_pkg::op_t                op,
	input  slri_pkg::link_t              prev,
	input  logic                         next_valid,
	input  logic signed [slri_pkg::VAL_W-1:0] next_value,
	output slri_pkg::link_t              self,
	output logic                         eq,
	output logic                         valid_d,
	output logic signed [slri_pkg::VAL_W-1:0] value_d
);
	import slri_pkg::*;

	logic                    valid_q;
	logic signed [VAL_W-1:0] value_q;
	logic                    ge;

	assign ge = valid_q && (value_q >= op.value);
	assign eq = valid_q && (value_q == op.value);

	assign self.valid = valid_q;
	assign self.ge    = ge;
	assign self.value = value_q;

	always_comb begin
		valid_d = valid_q;
		value_d = value_q;
		if (op.ins) begin
			valid_d = valid_q | prev.valid;
			if (prev.ge) begin
				value_d = prev.value;
			end else if (prev.valid && (ge || !valid_q)) begin
				value_d = op.value;
			end
		end else if (op.rem && ge) begin
			valid_d = next_valid;
			value_d = next_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end
endmodule

// ===== src/sorted_list_insert_remove_core.sv =====
// Top level of the sorted list core: cell chain, count and result registers.
// Usage:
//   Present command (0 insert, 1 remove) and a signed 32-bit value with start
//   high; the request is taken at a rising edge where start is high and busy
//   is low. busy stays low, so a new request may come every cycle.
//   The result (status, count, smallest) appears on the ports in the cycle
//   after the request, marked by done for exactly one cycle.
//   Throughput: one request per cycle. Each of the CAPACITY cells compares its
//   entry against the value and shifts toward or away from its neighbor in
//   the same cycle, so every cell loads its part of the new list at the same edge.
//   status: ok, full (insert into a full list), empty (remove from an empty
//   list) or not found; a failing request leaves the list unchanged.
//   count is the entry count after the request; smallest is the first entry,
//   or 0 when the list is empty.
//   Reset (arst_n low, asynchronous) empties the list and clears done; no
//   clearing pass is needed, entries beyond the count are never read.
//   The receiver cannot stall: a result must be taken in its done cycle.
`include "sorted_list_insert_remove_core_defines.svh"
module sorted_list_insert_remove_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  command,
	input  logic signed [slri_pkg::VAL_W-1:0]     value,
	output logic                                  done,
	output logic [1:0]                            status,
	output logic [slri_pkg::OUT_CNT_W-1:0]        count,
	output logic signed [slri_pkg::VAL_W-1:0]     smallest
);
	import slri_pkg::*;

	logic                    accept;
	logic                    is_remove;
	logic                    full;
	logic                    found;
	op_t                     op;
	link_t                   links   [CAPACITY+2];
	logic [CAPACITY-1:0]     eqs;
	logic [CAPACITY-1:0]     valids;
	logic [CAPACITY-1:0]     valid_next;
	logic signed [VAL_W-1:0] value_next [CAPACITY];
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_d;
	status_t                 status_d;
	status_t                 status_q;
	logic                    done_q;
	logic signed [VAL_W-1:0] smallest_q;

	assign busy      = 1'b0;
	assign accept    = start && !busy;
	assign is_remove = (command == CMD_REMOVE);
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign found     = |eqs;

	assign op.ins   = accept && !is_remove && !full;
	assign op.rem   = accept && is_remove && found;
	assign op.value = value;

	assign links[0].valid  = 1'b1;
	assign links[0].ge     = 1'b0;
	assign links[0].value  = value;
	assign links[CAPACITY+1] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		link_t cell_link;
		slri_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.prev       (links[i]),
			.next_valid (links[i+2].valid),
			.next_value (links[i+2].value),
			.self       (cell_link),
			.eq         (eqs[i]),
			.valid_d    (valid_next[i]),
			.value_d    (value_next[i])
		);
		assign links[i+1] = cell_link;
		assign valids[i]  = cell_link.valid;
	end

	always_comb begin
		count_d  = count_q;
		status_d = ST_OK;
		if (!is_remove) begin
			if (full) begin
				status_d = ST_FULL;
			end else begin
				count_d = count_q + CNT_W'(1);
			end
		end else if (count_q == '0) begin
			status_d = ST_EMPTY;
		end else if (!found) begin
			status_d = ST_NOTFOUND;
		end else begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q   <= status_d;
			smallest_q <= valid_next[0] ? value_next[0] : '0;
		end
	end

	assign done     = done_q;
	assign status   = status_q;
	assign count    = OUT_CNT_W'(count_q);
	assign smallest = smallest_q;

	`SLRI_ASSERT(a_done_follows_request, clk, arst_n, accept |=> done, "request without result")
	`SLRI_ASSERT(a_no_spurious_done, clk, arst_n, !accept |=> !done, "result without request")
	`SLRI_ASSERT(a_valid_contiguous, clk, arst_n, (valids & ~{valids[CAPACITY-2:0], 1'b1}) == '0, "gap in stored entries")
	`SLRI_ASSERT(a_count_matches_cells, clk, arst_n, count_q == CNT_W'($countones(valids)), "count disagrees with cells")
endmodule

// ===== bench/sorted_list_insert_remove_core_tb.sv =====
// Testbench for the sorted list core: directed and random insert/remove requests against a queue-based mirror.
module sorted_list_insert_remove_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import slri_pkg::*;

	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

	typedef struct {
		status_t                 status;
		logic [OUT_CNT_W-1:0]    count;
		logic signed [VAL_W-1:0] smallest;
	} list_result_t;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic                          command;
	logic signed [VAL_W-1:0]       value;
	logic                          done;
	logic [1:0]                    status;
	logic [OUT_CNT_W-1:0]          count;
	logic signed [VAL_W-1:0]       smallest;

	logic signed [VAL_W-1:0] sorted_mirror[$];
	list_result_t            pending_results[$];
	int                      mismatches = 0;
	int                      burst_left = 0;
	bit                      gapless_stretch = 0;

	sorted_list_insert_remove_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.command  (command),
		.value    (value),
		.done     (done),
		.status   (status),
		.count    (count),
		.smallest (smallest)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic apply_list_op(input cmd_t cmd, input logic signed [VAL_W-1:0] v);
		list_result_t res;
		int pos;
		pos = 0;
		if (cmd == CMD_INSERT) begin
			if (sorted_mirror.size() >= CAPACITY) begin
				res.status = ST_FULL;
			end else begin
				while (pos < sorted_mirror.size() && sorted_mirror[pos] < v)
					pos++;
				sorted_mirror.insert(pos, v);
				res.status = ST_OK;
			end
		end else begin
			if (sorted_mirror.size() == 0) begin
				res.status = ST_EMPTY;
			end else begin
				while (pos < sorted_mirror.size() && sorted_mirror[pos] != v)
					pos++;
				if (pos >= sorted_mirror.size()) begin
					res.status = ST_NOTFOUND;
				end else begin
					sorted_mirror.delete(pos);
					res.status = ST_OK;
				end
			end
		end
		res.count    = OUT_CNT_W'(sorted_mirror.size());
		res.smallest = (sorted_mirror.size() != 0) ? sorted_mirror[0] : '0;
		pending_results.push_back(res);
	endtask

	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			start   = 1'b0;
			command = 1'($urandom);
			value   = $urandom;
		end
	endtask

	task automatic pace_sender();
		int gap;
		if (gapless_stretch)
			return;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			idle_cycles(gap);
		end
	endtask

	task automatic send_request(input cmd_t cmd, input logic signed [VAL_W-1:0] v);
		@(negedge clk);
		start   = 1'b1;
		command = cmd;
		value   = v;
		do
			@(posedge clk);
		while (busy);
		apply_list_op(cmd, v);
		pace_sender();
	endtask

	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result status=%0d count=%0d smallest=%0d",
					$time, status, count, smallest);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status, status);
					mismatches++;
				end
				if (count !== want.count) begin
					$display("%0t: count expected %0d actual %0d", $time, want.count, count);
					mismatches++;
				end
				if (smallest !== want.smallest) begin
					$display("%0t: smallest expected %0d actual %0d",
						$time, want.smallest, smallest);
					mismatches++;
				end
			end
		end
	end

	task automatic test_empty_and_extremes();
		send_request(CMD_REMOVE, 0);
		send_request(CMD_INSERT, VAL_MAX);
		send_request(CMD_INSERT, VAL_MIN);
		send_request(CMD_INSERT, 0);
		send_request(CMD_INSERT, -1);
		send_request(CMD_INSERT, VAL_MIN);
		send_request(CMD_INSERT, VAL_MAX);
		send_request(CMD_REMOVE, 7);
		send_request(CMD_REMOVE, VAL_MIN);
		send_request(CMD_REMOVE, VAL_MAX);
		send_request(CMD_INSERT, 32'sh5555_5555);
		send_request(CMD_INSERT, 32'shAAAA_AAAA);
	endtask

	task automatic test_full_store();
		while (sorted_mirror.size() < CAPACITY)
			send_request(CMD_INSERT, $urandom);
		send_request(CMD_INSERT, 1);
		send_request(CMD_REMOVE, -1);
		send_request(CMD_REMOVE, 12345);
	endtask

	task automatic test_random_traffic(input int n_items);
		logic signed [VAL_W-1:0] corners[4];
		logic signed [VAL_W-1:0] v;
		cmd_t cmd;
		int insert_pct;
		int sel;
		corners = '{VAL_MIN, VAL_MAX, 0, -1};
		insert_pct = 75;
		for (int i = 0; i < n_items; i++) begin
			if (i % 60 == 0)
				insert_pct = ((i / 60) % 2 == 0) ? 75 : 25;
			gapless_stretch = ((i / 200) % 3 == 2);
			cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
			sel = $urandom_range(0, 99);
			if (sel < 20)
				v = $urandom;
			else if (sel < 55 && sorted_mirror.size() != 0)
				v = sorted_mirror[$urandom_range(0, sorted_mirror.size() - 1)];
			else if (sel < 85)
				v = int'($urandom_range(0, 8)) - 4;
			else
				v = corners[$urandom_range(0, 3)];
			send_request(cmd, v);
		end
		gapless_stretch = 0;
	endtask

	initial begin
		int guard;
		arst_n  = 1'b0;
		start   = 1'b0;
		command = 1'b0;
		value   = '0;
		clk     = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_empty_and_extremes();
		test_full_store();
		test_random_traffic(1420);

		idle_cycles(1);
		guard = 0;
		while (pending_results.size() != 0 && guard < 100) begin
			@(posedge clk);
			guard++;
		end
		idle_cycles(3);
		if (pending_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_results.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("%0t: timeout", $time);
		$display("CHECKS FAILED");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+src
src/slri_pkg.sv
src/slri_cell.sv
src/sorted_list_insert_remove_core.sv
bench/sorted_list_insert_remove_core_tb.sv
